/* src/tbp_pkg.sv */
package tbp_pkg;

    localparam int GHIST_BITS_DEF    = 9;
    localparam int LHIST_BITS_DEF    = 10;
    localparam int PC_INDEX_BITS_DEF = 10;
    localparam int PC_W              = 32;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_TRAIN   = 1'b1;

    typedef logic [1:0] ctr_t;

    localparam ctr_t CTR_MIN     = 2'd0;
    localparam ctr_t CTR_MAX     = 2'd3;
    localparam ctr_t CTR_WEAK_NT = 2'd1;

    // Upper half of the counter range votes taken (or local, for the chooser).
    function automatic logic ctr_taken(input ctr_t c);
        return c[1];
    endfunction

    // Saturating step up or down.
    function automatic ctr_t ctr_train(input ctr_t c, input logic up);
        ctr_t r;
        r = c;
        if (up) begin
            if (c != CTR_MAX) r = c + 2'd1;
        end else begin
            if (c != CTR_MIN) r = c - 2'd1;
        end
        return r;
    endfunction

endpackage

/* src/tournament_branch_predictor_core.sv */
// Tournament branch predictor. Each transaction on the s_ channel is either a
// predict (s_op = 0), which returns one m_predict_taken transaction, or a train
// (s_op = 1) with the resolved s_outcome, which returns nothing. The local side
// looks up a per-branch history (indexed by the low PC_INDEX_BITS of s_pc) and
// uses it to pick a 2-bit counter; the global side and the chooser use the
// global history. A train moves the chooser only when the last predict's two
// guesses disagreed, then trains both counter tables and shifts the outcome into
// both histories. The block takes one transaction per cycle unless stalled; an
// accepted predict passes s1_valid_reg and s2_valid_reg before m_valid rises.
// It is a three-stage pipeline around four single-port-read RAMs (history
// table read, counter reads, counter update and write-back), with forwarding
// of the write made in the same cycle as each read. While m_valid is high and
// m_ready low the whole pipeline holds, so s_ready drops too. After reset a
// clearing pass writes the reset values into all tables, one entry per cycle,
// stepping its index through 2^max(GHIST_BITS, LHIST_BITS, PC_INDEX_BITS)
// values (1024 with the default sizes); s_ready stays low during that pass.
module tournament_branch_predictor_core #(
    parameter int GHIST_BITS    = tbp_pkg::GHIST_BITS_DEF,
    parameter int LHIST_BITS    = tbp_pkg::LHIST_BITS_DEF,
    parameter int PC_INDEX_BITS = tbp_pkg::PC_INDEX_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_op,
    input  logic [tbp_pkg::PC_W-1:0] s_pc,
    input  logic                    s_outcome,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_predict_taken
);

    import tbp_pkg::*;

    localparam int LHT_DEPTH = 1 << PC_INDEX_BITS;
    localparam int LC_DEPTH  = 1 << LHIST_BITS;
    localparam int GC_DEPTH  = 1 << GHIST_BITS;
    localparam int CLR_BITS  =
        (GHIST_BITS > LHIST_BITS) ?
            ((GHIST_BITS > PC_INDEX_BITS) ? GHIST_BITS : PC_INDEX_BITS) :
            ((LHIST_BITS > PC_INDEX_BITS) ? LHIST_BITS : PC_INDEX_BITS);

    typedef logic [GHIST_BITS-1:0]    ghist_t;
    typedef logic [LHIST_BITS-1:0]    lhist_t;
    typedef logic [PC_INDEX_BITS-1:0] pidx_t;

    // Pipeline advance: output register empty or being drained.
    logic adv;
    logic s_accept;

    // Clearing pass after reset.
    logic                clr_active_reg;
    logic [CLR_BITS-1:0] clr_idx_reg;

    // Global history, updated when a train is accepted (needs only the outcome).
    ghist_t ghist_reg;

    // Stage 1: history table data arrives.
    logic   s1_valid_reg;
    logic   s1_op_reg;
    logic   s1_taken_reg;
    pidx_t  s1_pidx_reg;
    ghist_t s1_gidx_reg;
    lhist_t lht_rdata;
    lhist_t s1_lhist;
    lhist_t s1_lhist_new;
    logic   s1_lht_we;

    logic   lht_fwd_valid_reg;
    pidx_t  lht_fwd_addr_reg;
    lhist_t lht_fwd_data_reg;

    // Stage 2: counter data arrives, predict or update.
    logic   s2_valid_reg;
    logic   s2_op_reg;
    logic   s2_taken_reg;
    lhist_t s2_lhist_reg;
    ghist_t s2_gidx_reg;
    ctr_t   lc_rdata;
    ctr_t   gc_rdata;
    ctr_t   cc_rdata;
    ctr_t   s2_lc;
    ctr_t   s2_gc;
    ctr_t   s2_cc;
    ctr_t   s2_lc_new;
    ctr_t   s2_gc_new;
    ctr_t   s2_cc_new;
    logic   s2_train_we;
    logic   s2_local_guess;
    logic   s2_global_guess;
    logic   s2_pick;

    logic   lc_fwd_valid_reg;
    lhist_t lc_fwd_addr_reg;
    ctr_t   lc_fwd_data_reg;
    logic   g_fwd_valid_reg;
    ghist_t g_fwd_addr_reg;
    ctr_t   gc_fwd_data_reg;
    ctr_t   cc_fwd_data_reg;

    logic   last_local_reg;
    logic   last_global_reg;

    // Output register.
    logic   m_valid_reg;
    logic   m_taken_reg;

    // RAM write ports, muxed between clearing pass and pipeline.
    logic   lht_we;
    pidx_t  lht_waddr;
    lhist_t lht_wdata;
    logic   lc_we;
    lhist_t lc_waddr;
    ctr_t   lc_wdata;
    logic   g_we;
    ghist_t g_waddr;
    ctr_t   gc_wdata;
    ctr_t   cc_wdata;

    assign adv      = !m_valid_reg || m_ready;
    assign s_ready  = adv && !clr_active_reg;
    assign s_accept = s_valid && s_ready;

    // Stage 1 logic: forward the history written in the cycle of our read.
    assign s1_lhist = (lht_fwd_valid_reg && (lht_fwd_addr_reg == s1_pidx_reg)) ?
                      lht_fwd_data_reg : lht_rdata;
    assign s1_lhist_new = lhist_t'({s1_lhist, s1_taken_reg});
    assign s1_lht_we    = adv && s1_valid_reg && (s1_op_reg == OP_TRAIN);

    // Stage 2 logic: forward counters written in the cycle of our read.
    assign s2_lc = (lc_fwd_valid_reg && (lc_fwd_addr_reg == s2_lhist_reg)) ?
                   lc_fwd_data_reg : lc_rdata;
    assign s2_gc = (g_fwd_valid_reg && (g_fwd_addr_reg == s2_gidx_reg)) ?
                   gc_fwd_data_reg : gc_rdata;
    assign s2_cc = (g_fwd_valid_reg && (g_fwd_addr_reg == s2_gidx_reg)) ?
                   cc_fwd_data_reg : cc_rdata;

    assign s2_local_guess  = ctr_taken(s2_lc);
    assign s2_global_guess = ctr_taken(s2_gc);
    assign s2_pick         = ctr_taken(s2_cc) ? s2_local_guess : s2_global_guess;

    assign s2_lc_new = ctr_train(s2_lc, s2_taken_reg);
    assign s2_gc_new = ctr_train(s2_gc, s2_taken_reg);
    // Move the chooser only when the kept guesses disagreed.
    assign s2_cc_new = (last_local_reg != last_global_reg) ?
                       ctr_train(s2_cc, last_local_reg == s2_taken_reg) : s2_cc;
    assign s2_train_we = adv && s2_valid_reg && (s2_op_reg == OP_TRAIN);

    always_comb begin
        if (clr_active_reg) begin
            lht_we    = 1'b1;
            lht_waddr = clr_idx_reg[PC_INDEX_BITS-1:0];
            lht_wdata = '0;
            lc_we     = 1'b1;
            lc_waddr  = clr_idx_reg[LHIST_BITS-1:0];
            lc_wdata  = CTR_WEAK_NT;
            g_we      = 1'b1;
            g_waddr   = clr_idx_reg[GHIST_BITS-1:0];
            gc_wdata  = CTR_WEAK_NT;
            cc_wdata  = CTR_WEAK_NT;
        end else begin
            lht_we    = s1_lht_we;
            lht_waddr = s1_pidx_reg;
            lht_wdata = s1_lhist_new;
            lc_we     = s2_train_we;
            lc_waddr  = s2_lhist_reg;
            lc_wdata  = s2_lc_new;
            g_we      = s2_train_we;
            g_waddr   = s2_gidx_reg;
            gc_wdata  = s2_gc_new;
            cc_wdata  = s2_cc_new;
        end
    end

    tbp_ram #(.WIDTH(LHIST_BITS), .DEPTH(LHT_DEPTH)) u_lht (
        .aclk    (aclk),
        .wr_en   (lht_we),
        .wr_addr (lht_waddr),
        .wr_data (lht_wdata),
        .rd_en   (adv),
        .rd_addr (s_pc[PC_INDEX_BITS-1:0]),
        .rd_data (lht_rdata)
    );

    tbp_ram #(.WIDTH(2), .DEPTH(LC_DEPTH)) u_lc (
        .aclk    (aclk),
        .wr_en   (lc_we),
        .wr_addr (lc_waddr),
        .wr_data (lc_wdata),
        .rd_en   (adv),
        .rd_addr (s1_lhist),
        .rd_data (lc_rdata)
    );

    tbp_ram #(.WIDTH(2), .DEPTH(GC_DEPTH)) u_gc (
        .aclk    (aclk),
        .wr_en   (g_we),
        .wr_addr (g_waddr),
        .wr_data (gc_wdata),
        .rd_en   (adv),
        .rd_addr (s1_gidx_reg),
        .rd_data (gc_rdata)
    );

    tbp_ram #(.WIDTH(2), .DEPTH(GC_DEPTH)) u_cc (
        .aclk    (aclk),
        .wr_en   (g_we),
        .wr_addr (g_waddr),
        .wr_data (cc_wdata),
        .rd_en   (adv),
        .rd_addr (s1_gidx_reg),
        .rd_data (cc_rdata)
    );

    // Control state: clearing pass, history, valids, kept guesses.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg    <= 1'b1;
            clr_idx_reg       <= '0;
            ghist_reg         <= '0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            lht_fwd_valid_reg <= 1'b0;
            lc_fwd_valid_reg  <= 1'b0;
            g_fwd_valid_reg   <= 1'b0;
            last_local_reg    <= 1'b0;
            last_global_reg   <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == '1) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (s_accept && (s_op == OP_TRAIN)) begin
                ghist_reg <= ghist_t'({ghist_reg, s_outcome});
            end
            if (adv) begin
                s1_valid_reg      <= s_accept;
                s2_valid_reg      <= s1_valid_reg;
                m_valid_reg       <= s2_valid_reg && (s2_op_reg == OP_PREDICT);
                lht_fwd_valid_reg <= s1_lht_we;
                lc_fwd_valid_reg  <= s2_train_we;
                g_fwd_valid_reg   <= s2_train_we;
                if (s2_valid_reg && (s2_op_reg == OP_PREDICT)) begin
                    last_local_reg  <= s2_local_guess;
                    last_global_reg <= s2_global_guess;
                end
            end
        end
    end

    // Payload: advance with the pipeline, hold on a stall.
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_op_reg        <= s_op;
            s1_taken_reg     <= s_outcome;
            s1_pidx_reg      <= s_pc[PC_INDEX_BITS-1:0];
            s1_gidx_reg      <= ghist_reg;
            s2_op_reg        <= s1_op_reg;
            s2_taken_reg     <= s1_taken_reg;
            s2_lhist_reg     <= s1_lhist;
            s2_gidx_reg      <= s1_gidx_reg;
            m_taken_reg      <= s2_pick;
            lht_fwd_addr_reg <= s1_pidx_reg;
            lht_fwd_data_reg <= s1_lhist_new;
            lc_fwd_addr_reg  <= s2_lhist_reg;
            lc_fwd_data_reg  <= s2_lc_new;
            g_fwd_addr_reg   <= s2_gidx_reg;
            gc_fwd_data_reg  <= s2_gc_new;
            cc_fwd_data_reg  <= s2_cc_new;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_predict_taken = m_taken_reg;

`ifndef NO_ASSERTIONS
    // No transaction is taken while the tables are being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !s_ready)
        else $error("input accepted during clearing pass");

    // Global history moves only on an accepted train.
    a_ghist_only_on_train: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_accept && (s_op == OP_TRAIN)) |=> $stable(ghist_reg))
        else $error("global history changed without a train");

    // A train leaving stage 2 produces no result.
    a_train_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && s2_valid_reg && (s2_op_reg == OP_TRAIN)) |=> !m_valid_reg)
        else $error("result produced by a train");

    // Kept guesses change only when a predict leaves stage 2.
    a_guess_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(adv && s2_valid_reg && (s2_op_reg == OP_PREDICT))
            |=> ($stable(last_local_reg) && $stable(last_global_reg)))
        else $error("kept guesses changed without a predict");

    // Stalled stage-1 transaction keeps its index.
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!adv && s1_valid_reg) |=> (s1_valid_reg && $stable(s1_pidx_reg)))
        else $error("stage 1 moved during a stall");
`endif

endmodule

/* src/tbp_ram.sv */
module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read returns the old contents on a same-address write.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
